// File: src/bgd_pkg.sv
package bgd_pkg;

	// field widths
	localparam int KEY_W      = 4;
	localparam int TIME_W     = 16;
	localparam int DELAY_W    = 15;
	localparam int CD_W       = 17;
	localparam int CLICK_W    = 8;
	localparam int PHASE_W    = 3;
	localparam int EVENT_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// sizing
	localparam int NUM_KEYS_DEF = 16;
	localparam int QUEUE_DEPTH  = 2;

	// key phases
	localparam logic [PHASE_W-1:0] PH_RELEASE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_PREPRESS = 3'd1;
	localparam logic [PHASE_W-1:0] PH_PRELONG  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LONGHOLD = 3'd3;
	localparam logic [PHASE_W-1:0] PH_MULTI    = 3'd4;

	// gesture events
	localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
	localparam logic [EVENT_W-1:0] EV_CLICK  = 3'd1;
	localparam logic [EVENT_W-1:0] EV_MULTI  = 3'd2;
	localparam logic [EVENT_W-1:0] EV_HOLD   = 3'd3;
	localparam logic [EVENT_W-1:0] EV_REPEAT = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_FIRST_DELAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP_LIMIT    = 3'd4;

	// register reset values
	localparam logic [TIME_W-1:0]  CLICK_THRESHOLD_RST    = 16'd50;
	localparam logic [TIME_W-1:0]  HOLD_THRESHOLD_RST     = 16'd1000;
	localparam logic [DELAY_W-1:0] HOLD_FIRST_DELAY_RST   = 15'd500;
	localparam logic [DELAY_W-1:0] HOLD_REPEAT_PERIOD_RST = 15'd100;
	localparam logic [TIME_W-1:0]  CLICK_GAP_LIMIT_RST    = 16'd250;

	typedef struct packed {
		logic [TIME_W-1:0]  click_threshold;
		logic [TIME_W-1:0]  hold_threshold;
		logic [DELAY_W-1:0] hold_first_delay;
		logic [DELAY_W-1:0] hold_repeat_period;
		logic [TIME_W-1:0]  click_gap_limit;
	} cfg_t;

	// per-key state record, all zero is the reset value
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [TIME_W-1:0]  press_time;
		logic [TIME_W-1:0]  gap_time;
		logic [CD_W-1:0]    countdown;
		logic [CLICK_W-1:0] clicks;
		logic [TIME_W-1:0]  hold_length;
	} key_state_t;

	// queued scan sample with its classification
	typedef struct packed {
		logic [KEY_W-1:0]  key_index;
		logic              pressed;
		logic [TIME_W-1:0] elapsed_ms;
		logic              in_range;
	} item_t;

	function automatic logic [TIME_W-1:0] sat_add16(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

// File: src/bgd_channels.sv
interface bgd_item_if import bgd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  key_index;
	logic              pressed;
	logic [TIME_W-1:0] elapsed_ms;

	modport source (output valid, key_index, pressed, elapsed_ms, input ready);
	modport sink (input valid, key_index, pressed, elapsed_ms, output ready);
endinterface

interface bgd_result_if import bgd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KEY_W-1:0]   key_echo;
	logic [EVENT_W-1:0] gesture_event;
	logic [CLICK_W-1:0] click_total;
	logic [PHASE_W-1:0] key_phase;
	logic [TIME_W-1:0]  last_hold_ms;

	modport source (output valid, key_echo, gesture_event, click_total, key_phase,
		last_hold_ms, input ready);
	modport sink (input valid, key_echo, gesture_event, click_total, key_phase,
		last_hold_ms, output ready);
endinterface

interface bgd_cfg_if import bgd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/bgd_ram.sv
module bgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/bgd_front.sv
module bgd_front import bgd_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bgd_item_if.sink    item,
	output logic        q_vld,
	output item_t       q_item,
	input  logic        q_pop
);

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	item_t            ent_q [QUEUE_DEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             push;
	item_t            new_item;

	function automatic logic [QPW-1:0] ptr_next(input logic [QPW-1:0] p);
		return (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// classify the sample: keys beyond the table leave state untouched
	always_comb begin
		new_item.key_index  = item.key_index;
		new_item.pressed    = item.pressed;
		new_item.elapsed_ms = item.elapsed_ms;
		new_item.in_range   = (32'(item.key_index) < 32'(NUM_KEYS));
	end

	assign item.ready = (cnt_q != QCW'(QUEUE_DEPTH));
	assign push       = item.valid && item.ready;
	assign q_vld      = (cnt_q != '0);
	assign q_item     = ent_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (q_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (cnt_q != '0))
		else $error("pop from empty queue");

endmodule

// File: src/bgd_back.sv
module bgd_back import bgd_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_vld,
	input  item_t       q_item,
	output logic        q_pop,
	bgd_result_if.source result
);

	localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int SW = $bits(key_state_t);

	function automatic logic [AW-1:0] key_addr(input logic [KEY_W-1:0] k);
		logic [AW+KEY_W-1:0] e;
		e = (AW+KEY_W)'(k);
		return e[AW-1:0];
	endfunction

	item_t              item_s1;
	logic               s1_vld_q;
	logic               out_vld_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [EVENT_W-1:0] out_event_q;
	logic [CLICK_W-1:0] out_clicks_q;
	logic [PHASE_W-1:0] out_phase_q;
	logic [TIME_W-1:0]  out_hold_q;
	logic [NUM_KEYS-1:0] valid_q;
	logic               wr_vld_q;
	logic [AW-1:0]      wr_addr_q;
	key_state_t         wr_state_q;

	logic               out_free;
	logic               s1_go;
	logic               s1_load;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      s1_addr;
	logic [SW-1:0]      rdata;
	logic               ram_we;
	key_state_t         cur;
	key_state_t         nxt;
	logic [EVENT_W-1:0] ev;
	logic               down;
	logic [TIME_W-1:0]  dt;

	// stage control: the execute stage moves when the output register frees up
	assign out_free = !out_vld_q || result.ready;
	assign s1_go    = s1_vld_q && out_free;
	assign s1_load  = !s1_vld_q || out_free;
	assign q_pop    = q_vld && s1_load;
	assign s1_addr  = key_addr(item_s1.key_index);
	assign raddr    = q_pop ? key_addr(q_item.key_index) : s1_addr;
	assign ram_we   = s1_go && item_s1.in_range;

	bgd_ram #(
		.WIDTH (SW),
		.DEPTH (NUM_KEYS),
		.AW    (AW)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (s1_addr),
		.wdata (nxt),
		.raddr (raddr),
		.rdata (rdata)
	);

	// current key state: last write wins, unwritten keys read as reset
	always_comb begin
		if (wr_vld_q && (wr_addr_q == s1_addr)) begin
			cur = wr_state_q;
		end else if (valid_q[s1_addr]) begin
			cur = key_state_t'(rdata);
		end else begin
			cur = '0;
		end
	end

	// per-key gesture update
	always_comb begin
		down = item_s1.pressed;
		dt   = item_s1.elapsed_ms;
		nxt  = cur;
		ev   = EV_NONE;

		// timers
		if (!down) begin
			if (cur.phase == PH_LONGHOLD) begin
				nxt.hold_length = cur.press_time;
			end
			nxt.press_time = '0;
		end else begin
			nxt.press_time = sat_add16(cur.press_time, dt);
		end
		if (cur.phase == PH_MULTI) begin
			nxt.gap_time = sat_add16(cur.gap_time, dt);
		end else begin
			nxt.gap_time = '0;
		end

		// phase machine
		case (cur.phase)
			PH_RELEASE: begin
				nxt.clicks = '0;
				if (down) begin
					nxt.phase = PH_PREPRESS;
				end
			end
			PH_PREPRESS: begin
				if (!down) begin
					nxt.phase = PH_RELEASE;
				end else if (nxt.press_time >= cfg.click_threshold) begin
					nxt.phase = PH_PRELONG;
				end
			end
			PH_PRELONG: begin
				if (!down) begin
					nxt.phase = PH_MULTI;
					if (cur.clicks != {CLICK_W{1'b1}}) begin
						nxt.clicks = cur.clicks + 1'b1;
					end
				end else if (nxt.press_time >= cfg.hold_threshold) begin
					nxt.phase     = PH_LONGHOLD;
					nxt.countdown = CD_W'(cfg.hold_first_delay);
					ev            = EV_HOLD;
				end
			end
			PH_LONGHOLD: begin
				if (!cur.countdown[CD_W-1] && (cur.countdown != '0)) begin
					nxt.countdown = cur.countdown - CD_W'(dt);
				end else begin
					nxt.countdown = CD_W'(cfg.hold_repeat_period);
					ev            = EV_REPEAT;
				end
				if (!down) begin
					nxt.phase = PH_RELEASE;
				end
			end
			PH_MULTI: begin
				if (nxt.gap_time >= cfg.click_gap_limit) begin
					if (cur.clicks > CLICK_W'(1)) begin
						ev = EV_MULTI;
					end else if (cur.clicks == CLICK_W'(1)) begin
						ev = EV_CLICK;
					end
					nxt.phase = PH_RELEASE;
				end else if (nxt.press_time >= cfg.click_threshold) begin
					nxt.phase = PH_PRELONG;
				end
			end
			default: begin
				nxt.phase = PH_RELEASE;
			end
		endcase
	end

	// execute stage payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
		end
	end

	// write-back tracking and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			valid_q  <= '0;
			wr_vld_q <= 1'b0;
		end else begin
			if (s1_load) begin
				s1_vld_q <= q_vld;
			end
			if (ram_we) begin
				valid_q[s1_addr] <= 1'b1;
				wr_vld_q         <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_addr_q  <= s1_addr;
			wr_state_q <= nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= s1_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_key_q <= item_s1.key_index;
			if (item_s1.in_range) begin
				out_event_q  <= ev;
				out_clicks_q <= nxt.clicks;
				out_phase_q  <= nxt.phase;
				out_hold_q   <= nxt.hold_length;
			end else begin
				out_event_q  <= EV_NONE;
				out_clicks_q <= '0;
				out_phase_q  <= PH_RELEASE;
				out_hold_q   <= '0;
			end
		end
	end

	assign result.valid         = out_vld_q;
	assign result.key_echo      = out_key_q;
	assign result.gesture_event = out_event_q;
	assign result.click_total   = out_clicks_q;
	assign result.key_phase     = out_phase_q;
	assign result.last_hold_ms  = out_hold_q;

	a_go_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> out_vld_q)
		else $error("finished transaction did not reach output register");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(s1_addr)])
		else $error("written key not marked valid");

	a_hold_in_longhold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_event_q == EV_HOLD)) |-> (out_phase_q == PH_LONGHOLD))
		else $error("long hold start outside long hold phase");

endmodule

// File: src/button_gesture_detector_unit.sv
// Per-key button gesture classifier. Each scan sample (key, level, elapsed ms) yields
// exactly one result with the key's phase, click count, last hold length and at most
// one event (click, multi-click, long hold start, hold repeat). A sustained rate of one
// sample per clock is reached while the result channel is ready, same key or not: the
// per-key state lives in a single-write, single-read RAM with a one-deep write-back
// forward, and one read-modify-write per cycle sets that figure. A sample passes the
// queue, the state read and the output register in turn; the last holds while the
// result channel is not ready. Keys at or above NUM_KEYS echo the key with all other
// fields zero and leave state alone. The user must write the five threshold registers
// through the cfg channel only while the block is idle; the block does not enforce
// this. Indexes past the last register are ignored.
module button_gesture_detector_unit import bgd_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bgd_item_if.sink     item,
	bgd_result_if.source result,
	bgd_cfg_if.sink      cfg
);

	cfg_t  cfg_q;
	logic  q_vld;
	item_t q_item;
	logic  q_pop;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_threshold    <= CLICK_THRESHOLD_RST;
			cfg_q.hold_threshold     <= HOLD_THRESHOLD_RST;
			cfg_q.hold_first_delay   <= HOLD_FIRST_DELAY_RST;
			cfg_q.hold_repeat_period <= HOLD_REPEAT_PERIOD_RST;
			cfg_q.click_gap_limit    <= CLICK_GAP_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CLICK_THRESHOLD:    cfg_q.click_threshold    <= cfg.data;
				REG_HOLD_THRESHOLD:     cfg_q.hold_threshold     <= cfg.data;
				REG_HOLD_FIRST_DELAY:   cfg_q.hold_first_delay   <= cfg.data[DELAY_W-1:0];
				REG_HOLD_REPEAT_PERIOD: cfg_q.hold_repeat_period <= cfg.data[DELAY_W-1:0];
				REG_CLICK_GAP_LIMIT:    cfg_q.click_gap_limit    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	bgd_front #(
		.NUM_KEYS (NUM_KEYS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_vld  (q_vld),
		.q_item (q_item),
		.q_pop  (q_pop)
	);

	bgd_back #(
		.NUM_KEYS (NUM_KEYS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_vld  (q_vld),
		.q_item (q_item),
		.q_pop  (q_pop),
		.result (result)
	);

endmodule
